>>> design/alr_pkg.sv
// ----------------------------------------------------------------------------
// alr_pkg: shared types and constants of the anti-aliased line rasterizer
// Widths, request codes, line modes, controller states and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package alr_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;
	localparam int ACC_W      = COORD_BITS + FRAC_BITS;
	localparam int OUT_W      = 13;
	localparam int WGT_W      = 8;
	localparam int COLOR_W    = 24;
	localparam int Q_W        = FRAC_BITS + 1;
	localparam int REM_W      = COORD_BITS + 1;
	localparam int DCNT_W     = $clog2(FRAC_BITS + 1);

	localparam logic [WGT_W-1:0] WGT_FULL = {WGT_W{1'b1}};

	// request codes
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_VERT  = 2'd1,
		MODE_HORZ  = 2'd2,
		MODE_SLOPE = 2'd3
	} line_mode_t;

	typedef enum logic {
		ST_READY = 1'b0,
		ST_DIV   = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic div_run;
	} cmd_t;

	typedef struct packed {
		logic start_sloped;
		logic active;
		logic div_done;
	} sts_t;

	typedef struct packed {
		logic [OUT_W-1:0]   pixel_a_x;
		logic [OUT_W-1:0]   pixel_a_y;
		logic [WGT_W-1:0]   weight_a;
		logic [OUT_W-1:0]   pixel_b_x;
		logic [OUT_W-1:0]   pixel_b_y;
		logic [WGT_W-1:0]   weight_b;
		logic               has_pair;
		logic [COLOR_W-1:0] color_rgb;
		logic               last;
	} pix_t;

endpackage

>>> design/alr_req_if.sv
// ----------------------------------------------------------------------------
// alr_req_if: request channel of the line rasterizer
// Start or step requests with the two line endpoints.
// ----------------------------------------------------------------------------
interface alr_req_if;
	import alr_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  req_type;
	logic [COORD_BITS-1:0] x_start;
	logic [COORD_BITS-1:0] y_start;
	logic [COORD_BITS-1:0] x_end;
	logic [COORD_BITS-1:0] y_end;

	modport source (output valid, req_type, x_start, y_start, x_end, y_end, input ready);
	modport sink (input valid, req_type, x_start, y_start, x_end, y_end, output ready);

endinterface

>>> design/alr_pix_if.sv
// ----------------------------------------------------------------------------
// alr_pix_if: pixel channel of the line rasterizer
// One pixel or pixel pair with weights, pair flag, color and end-of-line flag per active step request.
// ----------------------------------------------------------------------------
interface alr_pix_if;
	import alr_pkg::*;

	logic               valid;
	logic               ready;
	logic [OUT_W-1:0]   pixel_a_x;
	logic [OUT_W-1:0]   pixel_a_y;
	logic [WGT_W-1:0]   weight_a;
	logic [OUT_W-1:0]   pixel_b_x;
	logic [OUT_W-1:0]   pixel_b_y;
	logic [WGT_W-1:0]   weight_b;
	logic               has_pair;
	logic [COLOR_W-1:0] color_rgb;
	logic               last;

	modport source (output valid, pixel_a_x, pixel_a_y, weight_a, pixel_b_x, pixel_b_y,
		weight_b, has_pair, color_rgb, last, input ready);
	modport sink (input valid, pixel_a_x, pixel_a_y, weight_a, pixel_b_x, pixel_b_y,
		weight_b, has_pair, color_rgb, last, output ready);

endinterface

>>> design/alr_div.sv
// ----------------------------------------------------------------------------
// alr_div: bit-serial gradient divider
// Restoring division of minor_delta * 2^FRAC_BITS by major_delta, one
// quotient bit per cycle. Minor delta never exceeds major delta, so the
// quotient fits in FRAC_BITS+1 bits.
// ----------------------------------------------------------------------------
module alr_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic                          run,
	input  logic [alr_pkg::COORD_BITS-1:0] dividend,
	input  logic [alr_pkg::COORD_BITS-1:0] divisor,
	output logic                          done,
	output logic [alr_pkg::Q_W-1:0]        quotient
);
	import alr_pkg::*;

	logic [REM_W-1:0]      rem_q;
	logic [COORD_BITS-1:0] dvs_q;
	logic [Q_W-1:0]        quo_q;
	logic [DCNT_W-1:0]     cnt_q;
	logic                  ge;
	logic [REM_W-1:0]      diff;
	logic [REM_W-1:0]      rem_next;

	// one restoring step
	assign ge       = rem_q >= {1'b0, dvs_q};
	assign diff     = rem_q - {1'b0, dvs_q};
	assign rem_next = (ge ? diff : rem_q) << 1;
	assign quotient = {quo_q[Q_W-2:0], ge};
	assign done     = run && (cnt_q == '0);

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= DCNT_W'(FRAC_BITS);
		end else if (run && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= {1'b0, dividend};
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (run) begin
			rem_q <= rem_next;
			quo_q <= quotient;
		end
	end

endmodule

>>> design/alr_ctrl.sv
// ----------------------------------------------------------------------------
// alr_ctrl: rasterizer controller
// Handshake control, output slot valid and the wait for the gradient divider.
// ----------------------------------------------------------------------------
module alr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_type,
	output logic          req_ready,
	output logic          pix_valid,
	input  logic          pix_ready,
	input  alr_pkg::sts_t sts,
	output alr_pkg::cmd_t cmd
);
	import alr_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        accept;

	assign req_ready = (state_q == ST_READY) && (!out_valid_q || pix_ready);
	assign accept    = req_valid && req_ready;
	assign pix_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_READY: begin
				if (accept && req_type == REQ_START && sts.start_sloped) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) state_d = ST_READY;
			end
			default: state_d = ST_READY;
		endcase
	end

	// commands
	always_comb begin
		cmd.load    = accept && (req_type == REQ_START);
		cmd.step    = accept && (req_type == REQ_STEP);
		cmd.div_run = (state_q == ST_DIV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_READY;
		end else begin
			state_q <= state_d;
		end
	end

	// output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step && sts.active) begin
			out_valid_q <= 1'b1;
		end else if (pix_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_slope_waits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && sts.start_sloped |=> state_q == ST_DIV && !req_ready)
		else $error("sloped start did not wait for divider");

	a_div_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && !sts.div_done |=> state_q == ST_DIV)
		else $error("divider wait left early");

	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && sts.active |=> pix_valid)
		else $error("active step gave no pixel");

	a_no_accept_full: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |-> !accept)
		else $error("request taken while pixel slot blocked");

endmodule

>>> design/alr_dp.sv
// ----------------------------------------------------------------------------
// alr_dp: rasterizer datapath
// Line setup, walk registers, gradient divider, weights and pixel register.
// ----------------------------------------------------------------------------
module alr_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [alr_pkg::COLOR_W-1:0]    cfg_wdata,
	input  logic [alr_pkg::COORD_BITS-1:0] x_start,
	input  logic [alr_pkg::COORD_BITS-1:0] y_start,
	input  logic [alr_pkg::COORD_BITS-1:0] x_end,
	input  logic [alr_pkg::COORD_BITS-1:0] y_end,
	input  alr_pkg::cmd_t                  cmd,
	output alr_pkg::sts_t                  sts,
	output alr_pkg::pix_t                  pix
);
	import alr_pkg::*;

	// walk state
	logic                  active_q;
	line_mode_t            mode_q;
	logic                  steep_q;
	logic                  neg_q;
	logic [COORD_BITS-1:0] pos_q;
	logic [COORD_BITS-1:0] end_q;
	logic [ACC_W-1:0]      acc_q;
	logic [ACC_W-1:0]      slope_q;
	logic [COLOR_W-1:0]    color_q;
	pix_t                  pix_q;

	// setup decode
	logic [COORD_BITS-1:0] adx, ady;
	logic                  steep, swap;
	logic [COORD_BITS-1:0] a1, b1, a2, b2, amag, bmag;
	line_mode_t            mode_d;
	logic [COORD_BITS-1:0] pos_d, end_d, minor_d;

	// divider
	logic           div_done;
	logic [Q_W-1:0] quotient;

	// step decode
	logic [COORD_BITS-1:0]  minor;
	logic [COORD_BITS:0]    minor_p1;
	logic [FRAC_BITS-1:0]   frac;
	logic [FRAC_BITS+7:0]   wb_full;
	logic [WGT_W-1:0]       wb;
	logic                   is_last;
	pix_t                   pix_d;

	// endpoint setup
	always_comb begin
		adx   = (x_start > x_end) ? x_start - x_end : x_end - x_start;
		ady   = (y_start > y_end) ? y_start - y_end : y_end - y_start;
		steep = ady > adx;
		a1    = steep ? y_start : x_start;
		b1    = steep ? x_start : y_start;
		a2    = steep ? y_end : x_end;
		b2    = steep ? x_end : y_end;
		amag  = steep ? ady : adx;
		bmag  = steep ? adx : ady;
		swap  = a1 > a2;
		if (adx == '0) begin
			mode_d  = MODE_VERT;
			pos_d   = (y_start < y_end) ? y_start : y_end;
			end_d   = (y_start < y_end) ? y_end : y_start;
			minor_d = x_start;
		end else if (ady == '0) begin
			mode_d  = MODE_HORZ;
			pos_d   = (x_start < x_end) ? x_start : x_end;
			end_d   = (x_start < x_end) ? x_end : x_start;
			minor_d = y_start;
		end else begin
			mode_d  = MODE_SLOPE;
			pos_d   = swap ? a2 : a1;
			end_d   = swap ? a1 : a2;
			minor_d = swap ? b2 : b1;
		end
	end

	assign sts.start_sloped = (mode_d == MODE_SLOPE);
	assign sts.active       = active_q;
	assign sts.div_done     = div_done;

	alr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.load),
		.run      (cmd.div_run),
		.dividend (bmag),
		.divisor  (amag),
		.done     (div_done),
		.quotient (quotient)
	);

	// column decode
	always_comb begin
		minor    = acc_q[ACC_W-1:FRAC_BITS];
		frac     = acc_q[FRAC_BITS-1:0];
		minor_p1 = {1'b0, minor} + 1'b1;
		wb_full  = ({frac, 8'd0} - {8'd0, frac}) + (FRAC_BITS+8)'(1 << (FRAC_BITS - 1));
		wb       = wb_full[FRAC_BITS+7:FRAC_BITS];
		is_last  = (pos_q == end_q);
		pix_d.color_rgb = color_q;
		pix_d.last      = is_last;
		if (mode_q == MODE_SLOPE) begin
			pix_d.pixel_a_x = steep_q ? OUT_W'(minor) : OUT_W'(pos_q);
			pix_d.pixel_a_y = steep_q ? OUT_W'(pos_q) : OUT_W'(minor);
			pix_d.pixel_b_x = steep_q ? OUT_W'(minor_p1) : OUT_W'(pos_q);
			pix_d.pixel_b_y = steep_q ? OUT_W'(pos_q) : OUT_W'(minor_p1);
			pix_d.weight_a  = WGT_FULL - wb;
			pix_d.weight_b  = wb;
			pix_d.has_pair  = 1'b1;
		end else begin
			pix_d.pixel_a_x = (mode_q == MODE_VERT) ? OUT_W'(minor) : OUT_W'(pos_q);
			pix_d.pixel_a_y = (mode_q == MODE_VERT) ? OUT_W'(pos_q) : OUT_W'(minor);
			pix_d.pixel_b_x = '0;
			pix_d.pixel_b_y = '0;
			pix_d.weight_a  = WGT_FULL;
			pix_d.weight_b  = '0;
			pix_d.has_pair  = 1'b0;
		end
	end

	// line control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			mode_q   <= MODE_NONE;
			steep_q  <= 1'b0;
			neg_q    <= 1'b0;
			pos_q    <= '0;
			end_q    <= '0;
			acc_q    <= '0;
			slope_q  <= '0;
			color_q  <= '0;
		end else begin
			if (cfg_we) color_q <= cfg_wdata;
			if (cmd.load) begin
				active_q <= 1'b1;
				mode_q   <= mode_d;
				steep_q  <= (mode_d == MODE_SLOPE) && steep;
				neg_q    <= swap ? (b1 < b2) : (b2 < b1);
				pos_q    <= pos_d;
				end_q    <= end_d;
				acc_q    <= {minor_d, {FRAC_BITS{1'b0}}};
				slope_q  <= '0;
			end else if (div_done) begin
				slope_q <= neg_q ? ACC_W'(-ACC_W'(quotient)) : ACC_W'(quotient);
			end else if (cmd.step && active_q) begin
				if (is_last) begin
					active_q <= 1'b0;
				end else begin
					pos_q <= pos_q + 1'b1;
					acc_q <= acc_q + slope_q;
				end
			end
		end
	end

	// pixel register
	always_ff @(posedge clk) begin
		if (cmd.step && active_q) pix_q <= pix_d;
	end

	assign pix = pix_q;

endmodule

>>> design/antialiased_line_rasterizer.sv
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer: Wu-style anti-aliased line walker
// Top level joining controller, datapath and the two stream channels.
// ----------------------------------------------------------------------------
// A start request latches two endpoints and a step request returns the pixel
// or pair of one column, or nothing when no line is active. Step requests are
// taken one per cycle unless back-pressure holds the pixel output, with a
// registered pixel output in between. An axis-aligned start does not wait;
// a sloped start waits for the bit-serial divider that forms the gradient
// one quotient bit per cycle, and no request is taken during that wait. The
// color register may be written only while no line work is pending.
module antialiased_line_rasterizer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [alr_pkg::COLOR_W-1:0] cfg_wdata,
	alr_req_if.sink                     req,
	alr_pix_if.source                   pix
);
	import alr_pkg::*;

	cmd_t cmd;
	sts_t sts;
	pix_t pix_data;

	alr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.pix_valid (pix.valid),
		.pix_ready (pix.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	alr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.x_start   (req.x_start),
		.y_start   (req.y_start),
		.x_end     (req.x_end),
		.y_end     (req.y_end),
		.cmd       (cmd),
		.sts       (sts),
		.pix       (pix_data)
	);

	// pixel payload
	assign pix.pixel_a_x = pix_data.pixel_a_x;
	assign pix.pixel_a_y = pix_data.pixel_a_y;
	assign pix.weight_a  = pix_data.weight_a;
	assign pix.pixel_b_x = pix_data.pixel_b_x;
	assign pix.pixel_b_y = pix_data.pixel_b_y;
	assign pix.weight_b  = pix_data.weight_b;
	assign pix.has_pair  = pix_data.has_pair;
	assign pix.color_rgb = pix_data.color_rgb;
	assign pix.last      = pix_data.last;

endmodule
